// ===== rtl/btc_pkg.sv =====
// Package: shared widths, codes, state types and helpers for the tap/hold classifier.
package btc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
    localparam int CFG_IDX_W   = 1;
    localparam logic [1:0] TRIPLE_TAPS = 2'd3;

    localparam logic [CFG_WIDTH-1:0] HOLD_RESET    = CFG_WIDTH'(300);
    localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET = CFG_WIDTH'(50);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOLD_THRESHOLD = 1'b0,
        REG_TAP_TIMEOUT    = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        OWNER_NONE  = 3'b001,
        OWNER_BOOT  = 3'b010,
        OWNER_POWER = 3'b100
    } owner_t;

    typedef enum logic [3:0] {
        EV_NONE        = 4'd0,
        EV_BOOT_RESET  = 4'd1,
        EV_POWER_RESET = 4'd2,
        EV_TAP         = 4'd3,
        EV_TRIPLE_AP   = 4'd4,
        EV_WAKE        = 4'd5,
        EV_RUN         = 4'd6,
        EV_STOP        = 4'd7,
        EV_NO_ACTION   = 4'd8,
        EV_TIMEOUT     = 4'd9
    } event_t;

    typedef enum logic [1:0] {
        MODE_SHUTDOWN = 2'd0,
        MODE_IDLE     = 2'd1,
        MODE_RUNNING  = 2'd2,
        MODE_OTHER    = 2'd3
    } mode_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] hold_threshold;
        logic [CFG_WIDTH-1:0] tap_timeout;
    } cfg_t;

    typedef struct packed {
        owner_t                 owner;
        logic [COUNT_WIDTH-1:0] press_len;
        logic [1:0]             tap_cnt;
        logic [COUNT_WIDTH-1:0] since_tap;
    } state_t;

    typedef struct packed {
        logic       boot;
        logic       power;
        logic [1:0] mode;
    } tick_t;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + COUNT_WIDTH'(1);
    endfunction

endpackage

// ===== rtl/btc_if.sv =====
// Interfaces: tick input channel and event output channel.
interface btc_tick_if;
    logic       valid;
    logic       ready;
    logic       boot_pressed;
    logic       power_pressed;
    logic [1:0] device_mode;

    modport source (output valid, output boot_pressed, output power_pressed,
                    output device_mode, input ready);
    modport sink   (input valid, input boot_pressed, input power_pressed,
                    input device_mode, output ready);
endinterface

interface btc_event_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_code;
    logic [1:0] taps_pending;

    modport source (output valid, output event_code, output taps_pending, input ready);
    modport sink   (input valid, input event_code, input taps_pending, output ready);
endinterface

// ===== rtl/btc_cfg.sv =====
// Configuration registers: hold threshold and tap timeout.
module btc_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [btc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [btc_pkg::CFG_WIDTH-1:0]    cfg_wdata,
    output btc_pkg::cfg_t                    cfg
);

    btc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_threshold <= btc_pkg::HOLD_RESET;
            cfg_reg.tap_timeout    <= btc_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (btc_pkg::reg_idx_t'(cfg_index))
                btc_pkg::REG_HOLD_THRESHOLD: cfg_reg.hold_threshold <= cfg_wdata;
                btc_pkg::REG_TAP_TIMEOUT:    cfg_reg.tap_timeout    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/btc_step.sv =====
// Per-tick classification: next state and event from current state and one tick.
module btc_step
(
    input  btc_pkg::cfg_t   cfg,
    input  btc_pkg::state_t cur,
    input  btc_pkg::tick_t  tick,
    output btc_pkg::state_t nxt,
    output btc_pkg::event_t ev
);

    logic level;
    logic hold;
    logic timed_out;

    always_comb
    begin
        nxt           = cur;
        ev            = btc_pkg::EV_NONE;
        nxt.since_tap = btc_pkg::sat_inc(cur.since_tap);
        level         = (cur.owner == btc_pkg::OWNER_BOOT) ? tick.boot : tick.power;
        hold          = btc_pkg::CMP_WIDTH'(cur.press_len)
                        >= btc_pkg::CMP_WIDTH'(cfg.hold_threshold);

        if (cur.owner != btc_pkg::OWNER_NONE)
        begin
            if (level)
            begin
                nxt.press_len = btc_pkg::sat_inc(cur.press_len);
            end
            else
            begin
                if (cur.owner == btc_pkg::OWNER_BOOT)
                begin
                    if (hold)
                    begin
                        ev          = btc_pkg::EV_BOOT_RESET;
                        nxt.tap_cnt = 2'd0;
                    end
                end
                else if (hold)
                begin
                    ev          = btc_pkg::EV_POWER_RESET;
                    nxt.tap_cnt = 2'd0;
                end
                else
                begin
                    nxt.tap_cnt   = cur.tap_cnt + 2'd1;
                    nxt.since_tap = '0;
                    ev            = btc_pkg::EV_TAP;
                    if (nxt.tap_cnt == btc_pkg::TRIPLE_TAPS)
                    begin
                        ev          = btc_pkg::EV_TRIPLE_AP;
                        nxt.tap_cnt = 2'd0;
                    end
                end
                nxt.owner     = btc_pkg::OWNER_NONE;
                nxt.press_len = '0;
            end
        end

        if (nxt.owner == btc_pkg::OWNER_NONE)
        begin
            priority if (tick.boot)
            begin
                nxt.owner     = btc_pkg::OWNER_BOOT;
                nxt.press_len = btc_pkg::COUNT_WIDTH'(1);
            end
            else if (tick.power)
            begin
                nxt.owner     = btc_pkg::OWNER_POWER;
                nxt.press_len = btc_pkg::COUNT_WIDTH'(1);
            end
        end

        timed_out = btc_pkg::CMP_WIDTH'(nxt.since_tap)
                    > btc_pkg::CMP_WIDTH'(cfg.tap_timeout);

        if (ev == btc_pkg::EV_NONE && nxt.owner == btc_pkg::OWNER_NONE
            && nxt.tap_cnt != 2'd0 && timed_out)
        begin
            if (nxt.tap_cnt == 2'd1)
            begin
                unique case (btc_pkg::mode_t'(tick.mode))
                    btc_pkg::MODE_SHUTDOWN: ev = btc_pkg::EV_WAKE;
                    btc_pkg::MODE_IDLE:     ev = btc_pkg::EV_RUN;
                    btc_pkg::MODE_RUNNING:  ev = btc_pkg::EV_STOP;
                    default:                ev = btc_pkg::EV_NO_ACTION;
                endcase
            end
            else
            begin
                ev = btc_pkg::EV_TIMEOUT;
            end
            nxt.tap_cnt = 2'd0;
        end
    end

endmodule

// ===== rtl/button_tap_hold_classifier.sv =====
// Top level: button tap and hold classifier with input and result registers.
//
// Usage
//   tick  : one beat per polling tick (boot_pressed, power_pressed, device_mode).
//   evt   : exactly one beat per tick beat (event_code, taps_pending), in order.
//   cfg   : cfg_we/cfg_index/cfg_wdata write hold threshold (index 0) and tap
//           timeout (index 1); write only while the block is idle.
// Accepted ticks pass the input register, then the result register.
// Throughput: one tick per cycle while results are taken; the tick register
// feeds the step logic; state and result registers load in the same cycle.
// Stall: when evt is not taken the result holds; one further tick is held in
// the input register, then tick.ready drops until the result is taken.
// Reset: press owner none, counters and tap count zero, hold threshold 300,
// tap timeout 50, both channels empty.
module button_tap_hold_classifier
(
    input  logic                          clk,
    input  logic                          rst_n,
    btc_tick_if.sink                      tick,
    btc_event_if.source                   evt,
    input  logic                          cfg_we,
    input  logic [btc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [btc_pkg::CFG_WIDTH-1:0] cfg_wdata
);

    btc_pkg::cfg_t   cfg;
    btc_pkg::state_t state_reg;
    btc_pkg::state_t state_next;
    btc_pkg::tick_t  tick_reg;
    btc_pkg::event_t ev_next;
    logic            in_valid_reg;
    logic            out_valid_reg;
    logic [3:0]      event_reg;
    logic [1:0]      taps_reg;
    logic            advance;
    logic            fire;

    btc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    btc_step u_step
    (
        .cfg  (cfg),
        .cur  (state_reg),
        .tick (tick_reg),
        .nxt  (state_next),
        .ev   (ev_next)
    );

    assign advance    = !out_valid_reg || evt.ready;
    assign fire       = in_valid_reg && advance;
    assign tick.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{owner: btc_pkg::OWNER_NONE, press_len: '0,
                               tap_cnt: 2'd0, since_tap: '0};
        end
        else
        begin
            if (tick.ready)
            begin
                in_valid_reg <= tick.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.ready && tick.valid)
        begin
            tick_reg.boot  <= tick.boot_pressed;
            tick_reg.power <= tick.power_pressed;
            tick_reg.mode  <= tick.device_mode;
        end
        if (fire)
        begin
            event_reg <= ev_next;
            taps_reg  <= state_next.tap_cnt;
        end
    end

    assign evt.valid        = out_valid_reg;
    assign evt.event_code   = event_reg;
    assign evt.taps_pending = taps_reg;

endmodule

// ===== rtl/btc_checker.sv =====
// Port checker for the classifier, with its bind.
module btc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] event_code,
    input logic [1:0] taps_pending
);

    // stalled result beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_code)
        && $stable(taps_pending))
        else $error("result beat dropped or changed under stall");

    // input only stalls while a result beat is held off
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // third tap and every end of sequence leave no taps
    a_taps_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_code != btc_pkg::EV_NONE && event_code != btc_pkg::EV_TAP
        |-> taps_pending == 2'd0)
        else $error("taps pending after a clearing event");

    a_tap_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_code == btc_pkg::EV_TAP
        |-> taps_pending == 2'd1 || taps_pending == 2'd2)
        else $error("tap event with bad tap count");

    a_codes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_code <= btc_pkg::EV_TIMEOUT
        && taps_pending != btc_pkg::TRIPLE_TAPS)
        else $error("result out of range");

endmodule

bind button_tap_hold_classifier btc_checker u_btc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (tick.ready),
    .out_valid    (evt.valid),
    .out_ready    (evt.ready),
    .event_code   (evt.event_code),
    .taps_pending (evt.taps_pending)
);

// ===== sim/tb_button_tap_hold_classifier.sv =====
`timescale 1ns / 100ps
// Testbench for the tap/hold classifier: directed table, random gestures, predictor-checked beats.
module tb_button_tap_hold_classifier;

    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int HOLD_OFF_LEN  = 40;
    localparam int DIRECTED_ROWS = 25;
    localparam int NUM_PHASES    = 7;
    localparam int PHASE_TICKS   = 115;

    typedef struct packed {
        btc_pkg::event_t ev;
        logic [1:0]      taps;
    } outcome_t;

    typedef struct packed {
        logic            boot;
        logic            power;
        btc_pkg::mode_t  mode;
        bit              typed;
        btc_pkg::event_t ev;
        logic [1:0]      taps;
    } step_row_t;

    // hold threshold 2, tap timeout 1
    localparam step_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{1'b0, 1'b0, btc_pkg::MODE_SHUTDOWN, 1'b1, btc_pkg::EV_NONE,        2'd0},
        '{1'b0, 1'b1, btc_pkg::MODE_SHUTDOWN, 1'b0, btc_pkg::EV_NONE,        2'd0},
        '{1'b0, 1'b0, btc_pkg::MODE_SHUTDOWN, 1'b1, btc_pkg::EV_TAP,         2'd1},
        '{1'b0, 1'b0, btc_pkg::MODE_SHUTDOWN, 1'b0, btc_pkg::EV_NONE,        2'd0},
        '{1'b0, 1'b0, btc_pkg::MODE_SHUTDOWN, 1'b1, btc_pkg::EV_WAKE,        2'd0},
        '{1'b0, 1'b1, btc_pkg::MODE_RUNNING,  1'b0, btc_pkg::EV_NONE,        2'd0},
        '{1'b0, 1'b0, btc_pkg::MODE_RUNNING,  1'b0, btc_pkg::EV_NONE,        2'd0},
        '{1'b1, 1'b0, btc_pkg::MODE_RUNNING,  1'b0, btc_pkg::EV_NONE,        2'd0},
        '{1'b1, 1'b1, btc_pkg::MODE_RUNNING,  1'b0, btc_pkg::EV_NONE,        2'd0},
        '{1'b0, 1'b1, btc_pkg::MODE_RUNNING,  1'b1, btc_pkg::EV_BOOT_RESET,  2'd0},
        '{1'b0, 1'b1, btc_pkg::MODE_RUNNING,  1'b0, btc_pkg::EV_NONE,        2'd0},
        '{1'b0, 1'b0, btc_pkg::MODE_RUNNING,  1'b1, btc_pkg::EV_POWER_RESET, 2'd0},
        '{1'b0, 1'b1, btc_pkg::MODE_IDLE,     1'b0, btc_pkg::EV_NONE,        2'd0},
        '{1'b0, 1'b0, btc_pkg::MODE_IDLE,     1'b0, btc_pkg::EV_NONE,        2'd0},
        '{1'b1, 1'b1, btc_pkg::MODE_IDLE,     1'b0, btc_pkg::EV_NONE,        2'd0},
        '{1'b0, 1'b1, btc_pkg::MODE_IDLE,     1'b0, btc_pkg::EV_NONE,        2'd0},
        '{1'b0, 1'b0, btc_pkg::MODE_IDLE,     1'b0, btc_pkg::EV_NONE,        2'd0},
        '{1'b0, 1'b1, btc_pkg::MODE_IDLE,     1'b0, btc_pkg::EV_NONE,        2'd0},
        '{1'b0, 1'b0, btc_pkg::MODE_IDLE,     1'b1, btc_pkg::EV_TRIPLE_AP,   2'd0},
        '{1'b0, 1'b1, btc_pkg::MODE_OTHER,    1'b0, btc_pkg::EV_NONE,        2'd0},
        '{1'b0, 1'b0, btc_pkg::MODE_OTHER,    1'b0, btc_pkg::EV_NONE,        2'd0},
        '{1'b0, 1'b1, btc_pkg::MODE_OTHER,    1'b0, btc_pkg::EV_NONE,        2'd0},
        '{1'b0, 1'b0, btc_pkg::MODE_OTHER,    1'b0, btc_pkg::EV_NONE,        2'd0},
        '{1'b0, 1'b0, btc_pkg::MODE_OTHER,    1'b0, btc_pkg::EV_NONE,        2'd0},
        '{1'b0, 1'b0, btc_pkg::MODE_OTHER,    1'b1, btc_pkg::EV_TIMEOUT,     2'd0}
    };

    localparam logic [btc_pkg::CFG_WIDTH-1:0] PHASE_HOLD [NUM_PHASES] =
        '{16'd1, 16'd0, 16'd3, 16'd5, 16'd300, 16'hFFFF, 16'd12};
    localparam logic [btc_pkg::CFG_WIDTH-1:0] PHASE_TIMEOUT [NUM_PHASES] =
        '{16'd0, 16'd3, 16'd2, 16'd8, 16'd50, 16'd1, 16'hFFFF};

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    btc_pkg::reg_idx_t             cfg_index;
    logic [btc_pkg::CFG_WIDTH-1:0] cfg_wdata;

    btc_tick_if  tick_ch ();
    btc_event_if evt_ch ();

    button_tap_hold_classifier u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .evt       (evt_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state and settings
    logic [btc_pkg::CFG_WIDTH-1:0]   hold_thr;
    logic [btc_pkg::CFG_WIDTH-1:0]   tap_to;
    btc_pkg::owner_t                 cur_owner;
    logic [btc_pkg::COUNT_WIDTH-1:0] press_len;
    logic [btc_pkg::COUNT_WIDTH-1:0] since_tap;
    logic [1:0]                      taps;

    outcome_t expected_events [$];

    int errors;
    int ticks_sent;
    int beats_seen;
    int actions_seen;
    int cycles;
    int long_stalls;
    int settings_used;
    bit tx_gaps;
    bit rx_gaps;
    bit hold_off_req;

    initial clk = 1'b0;

    always
    begin
        #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("%0t: timeout, %0d beats still outstanding", $time, expected_events.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic outcome_t classify_tick(input logic b, input logic p,
                                               input btc_pkg::mode_t m);
        btc_pkg::event_t ev;
        logic            lvl;
        outcome_t        res;
        ev = btc_pkg::EV_NONE;
        if (since_tap != '1)
            since_tap++;
        if (cur_owner != btc_pkg::OWNER_NONE)
        begin
            lvl = (cur_owner == btc_pkg::OWNER_BOOT) ? b : p;
            if (lvl)
            begin
                if (press_len != '1)
                    press_len++;
            end
            else
            begin
                if (press_len >= hold_thr)
                begin
                    ev   = (cur_owner == btc_pkg::OWNER_BOOT) ? btc_pkg::EV_BOOT_RESET
                                                              : btc_pkg::EV_POWER_RESET;
                    taps = 2'd0;
                end
                else if (cur_owner == btc_pkg::OWNER_POWER)
                begin
                    taps      = taps + 2'd1;
                    since_tap = '0;
                    ev        = btc_pkg::EV_TAP;
                    if (taps == btc_pkg::TRIPLE_TAPS)
                    begin
                        ev   = btc_pkg::EV_TRIPLE_AP;
                        taps = 2'd0;
                    end
                end
                cur_owner = btc_pkg::OWNER_NONE;
                press_len = '0;
            end
        end
        if (cur_owner == btc_pkg::OWNER_NONE && (b || p))
        begin
            cur_owner = b ? btc_pkg::OWNER_BOOT : btc_pkg::OWNER_POWER;
            press_len = btc_pkg::COUNT_WIDTH'(1);
        end
        if (ev == btc_pkg::EV_NONE && cur_owner == btc_pkg::OWNER_NONE && taps != 2'd0
            && since_tap > tap_to)
        begin
            if (taps == 2'd1)
            begin
                case (m)
                    btc_pkg::MODE_SHUTDOWN: ev = btc_pkg::EV_WAKE;
                    btc_pkg::MODE_IDLE:     ev = btc_pkg::EV_RUN;
                    btc_pkg::MODE_RUNNING:  ev = btc_pkg::EV_STOP;
                    default:                ev = btc_pkg::EV_NO_ACTION;
                endcase
            end
            else
                ev = btc_pkg::EV_TIMEOUT;
            taps = 2'd0;
        end
        res.ev   = ev;
        res.taps = taps;
        return res;
    endfunction

    // entered and left right after a rising edge
    task automatic drive_tick(input step_row_t row);
        int       gap;
        outcome_t res;
        gap = tx_gaps ? $urandom_range(0, 11) : 0;
        if (gap != 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid         <= 1'b1;
        tick_ch.boot_pressed  <= row.boot;
        tick_ch.power_pressed <= row.power;
        tick_ch.device_mode   <= row.mode;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        res = classify_tick(row.boot, row.power, row.mode);
        if (row.typed)
        begin
            res.ev   = row.ev;
            res.taps = row.taps;
        end
        expected_events.push_back(res);
        ticks_sent++;
    endtask

    task automatic offer_tick(input logic b, input logic p);
        step_row_t row;
        row = '{b, p, btc_pkg::mode_t'($urandom_range(0, 3)), 1'b0, btc_pkg::EV_NONE, 2'd0};
        drive_tick(row);
    endtask

    task automatic finish_phase();
        tick_ch.valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [btc_pkg::CFG_WIDTH-1:0] hold,
                                  input logic [btc_pkg::CFG_WIDTH-1:0] to);
        cfg_we    <= 1'b1;
        cfg_index <= btc_pkg::REG_HOLD_THRESHOLD;
        cfg_wdata <= hold;
        @(posedge clk);
        cfg_index <= btc_pkg::REG_TAP_TIMEOUT;
        cfg_wdata <= to;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        hold_thr = hold;
        tap_to   = to;
        settings_used++;
    endtask

    function automatic logic stray_level();
        return ($urandom_range(0, 3) == 0);
    endfunction

    function automatic int short_len();
        if (hold_thr <= 16'd1)
            return $urandom_range(1, 3);
        return $urandom_range(1, (hold_thr > 16'd7) ? 6 : int'(hold_thr) - 1);
    endfunction

    function automatic int hold_len();
        if (hold_thr > 16'd400)
            return $urandom_range(1, 6);
        return (hold_thr == 16'd0) ? $urandom_range(1, 3) : int'(hold_thr) + $urandom_range(0, 2);
    endfunction

    task automatic press_gesture(input bit on_boot, input int len, input bit both_start);
        int k;
        for (k = 0; k < len; k++)
        begin
            if (on_boot)
                offer_tick(1'b1, (k == 0 && both_start) ? 1'b1 : stray_level());
            else
                offer_tick((k == 0) ? 1'b0 : stray_level(), 1'b1);
        end
        offer_tick(1'b0, on_boot ? stray_level() : 1'b0);
        repeat ($urandom_range(0, 2)) offer_tick(1'b0, 1'b0);
    endtask

    task automatic run_gestures(input int budget);
        int start;
        int span;
        start = ticks_sent;
        span  = (tap_to > 16'd60) ? 8 : int'(tap_to) + 2;
        while (ticks_sent - start < budget)
        begin
            case ($urandom_range(0, 11))
                0, 1, 2, 3: press_gesture(1'b0, short_len(), 1'b0);
                4:          press_gesture(1'b0, hold_len(), 1'b0);
                5:          press_gesture(1'b1, short_len(), 1'b0);
                6:          press_gesture(1'b1, hold_len(), 1'b0);
                7:          press_gesture(1'b1, short_len(), 1'b1);
                8, 9:       repeat ($urandom_range(0, span)) offer_tick(1'b0, 1'b0);
                default:    repeat ($urandom_range(1, 6)) offer_tick($urandom_range(0, 1),
                                                                     $urandom_range(0, 1));
            endcase
        end
    endtask

    initial
    begin : event_sink
        int       wait_cyc;
        outcome_t want;
        evt_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            wait_cyc = rx_gaps ? $urandom_range(0, 11) : 0;
            if (hold_off_req)
            begin
                wait_cyc    += HOLD_OFF_LEN;
                hold_off_req = 1'b0;
                long_stalls++;
            end
            if (wait_cyc != 0)
            begin
                evt_ch.ready <= 1'b0;
                repeat (wait_cyc) @(posedge clk);
            end
            evt_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!evt_ch.valid);
            beats_seen++;
            if (evt_ch.event_code != btc_pkg::EV_NONE)
                actions_seen++;
            if (expected_events.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat, expected nothing, actual event %0d taps %0d",
                         $time, evt_ch.event_code, evt_ch.taps_pending);
            end
            else
            begin
                want = expected_events.pop_front();
                if (evt_ch.event_code !== want.ev)
                begin
                    errors++;
                    $display("%0t: event_code expected %0d actual %0d",
                             $time, want.ev, evt_ch.event_code);
                end
                if (evt_ch.taps_pending !== want.taps)
                begin
                    errors++;
                    $display("%0t: taps_pending expected %0d actual %0d",
                             $time, want.taps, evt_ch.taps_pending);
                end
            end
        end
    end

    initial
    begin : stimulus
        int i;
        int ph;
        rst_n                 <= 1'b0;
        tick_ch.valid         <= 1'b0;
        tick_ch.boot_pressed  <= 1'b0;
        tick_ch.power_pressed <= 1'b0;
        tick_ch.device_mode   <= btc_pkg::MODE_SHUTDOWN;
        cfg_we                <= 1'b0;
        cfg_index             <= btc_pkg::REG_HOLD_THRESHOLD;
        cfg_wdata             <= '0;
        hold_thr  = btc_pkg::HOLD_RESET;
        tap_to    = btc_pkg::TIMEOUT_RESET;
        cur_owner = btc_pkg::OWNER_NONE;
        press_len = '0;
        since_tap = '0;
        taps      = 2'd0;
        tx_gaps   = 1'b1;
        rx_gaps   = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_settings(16'd2, 16'd1);
        for (i = 0; i < DIRECTED_ROWS; i++)
            drive_tick(DIRECTED[i]);
        finish_phase();

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            apply_settings(PHASE_HOLD[ph], PHASE_TIMEOUT[ph]);
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            if (ph == 2 || ph == 5)
            begin
                tx_gaps      = 1'b0;
                hold_off_req = 1'b1;
            end
            run_gestures(PHASE_TICKS);
            finish_phase();
        end

        $display("Ran %0d ticks under %0d register settings; %0d beats checked, %0d with events",
                 ticks_sent, settings_used, beats_seen, actions_seen);
        $display("Covered random gaps on both sides and %0d long result stalls",
                 long_stalls);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/btc_pkg.sv
rtl/btc_if.sv
rtl/btc_cfg.sv
rtl/btc_step.sv
rtl/button_tap_hold_classifier.sv
rtl/btc_checker.sv
sim/tb_button_tap_hold_classifier.sv
